[src/i2cms_pkg.sv]
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_START_WR = 3'd0,
    CMD_START_RD = 3'd1,
    CMD_LOAD_WR  = 3'd2,
    CMD_EVENT    = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    EV_START     = 4'd0,
    EV_REP_START = 4'd1,
    EV_SLAW_ACK  = 4'd2,
    EV_TX_ACK    = 4'd3,
    EV_SLAR_ACK  = 4'd4,
    EV_RX_ACK    = 4'd5,
    EV_RX_NACK   = 4'd6,
    EV_ARB_LOST  = 4'd7
  } bus_event_e;

  // one result word; tx_from_ram selects the buffer read data for tx_data
  typedef struct packed {
    logic       advance;
    logic       start;
    logic       stop;
    logic       ack;
    logic       irq_enable;
    logic       tx_valid;
    logic       tx_from_ram;
    logic [7:0] tx_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done;
    logic       error;
    logic [7:0] done_count;
  } result_t;

endpackage

[src/i2cms_ram.sv]
module i2cms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/i2cms_ctrl.sv]
module i2cms_ctrl #(
  parameter int TxDepth = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [2:0]                 cmd_i,
  input  logic [7:0]                 slave_addr_i,
  input  logic [7:0]                 xfer_len_i,
  input  logic [3:0]                 bus_event_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [3:0]                 wr_index_i,
  input  logic [7:0]                 wr_byte_i,
  output i2cms_pkg::result_t         res_o,
  output logic                       ram_we_o,
  output logic [$clog2(TxDepth)-1:0] ram_waddr_o,
  output logic [7:0]                 ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(TxDepth)-1:0] ram_raddr_o
);

  localparam int AW = $clog2(TxDepth);
  localparam logic [8:0] DepthLen = 9'(TxDepth);

  logic          active_q, active_d;
  logic [7:0]    addr_byte_q, addr_byte_d;
  logic [7:0]    total_q, total_d;
  logic [7:0]    remaining_q, remaining_d;
  logic [AW-1:0] ptr_q, ptr_d;

  logic [7:0]    rem_dec;
  logic [7:0]    len_clamped;
  logic [AW+3:0] widx_ext;
  logic [AW-1:0] ptr_inc;

  assign rem_dec     = (remaining_q == 8'd0) ? 8'd0 : remaining_q - 8'd1;
  assign len_clamped = ({1'b0, xfer_len_i} > DepthLen) ? DepthLen[7:0] : xfer_len_i;
  assign widx_ext    = {{AW{1'b0}}, wr_index_i};
  assign ptr_inc     = (ptr_q == AW'(TxDepth - 1)) ? '0 : ptr_q + AW'(1);

  always_comb begin
    res_o       = '0;
    active_d    = active_q;
    addr_byte_d = addr_byte_q;
    total_d     = total_q;
    remaining_d = remaining_q;
    ptr_d       = ptr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = widx_ext[AW-1:0];
    ram_wdata_o = wr_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q;

    unique case (i2cms_pkg::cmd_e'(cmd_i))
      i2cms_pkg::CMD_START_WR, i2cms_pkg::CMD_START_RD: begin
        if (active_q) begin
          res_o.error = 1'b1;
        end else begin
          addr_byte_d = {slave_addr_i[7:1], cmd_i[0]};
          total_d     = cmd_i[0] ? xfer_len_i : len_clamped;
          remaining_d = cmd_i[0] ? xfer_len_i : len_clamped;
          ptr_d       = '0;
          active_d    = 1'b1;
          res_o.advance    = 1'b1;
          res_o.start      = 1'b1;
          res_o.irq_enable = 1'b1;
        end
      end
      i2cms_pkg::CMD_LOAD_WR: begin
        ram_we_o = step_i && (widx_ext < (AW+4)'(TxDepth));
      end
      i2cms_pkg::CMD_EVENT: begin
        if (active_q) begin
          case (bus_event_i)
            i2cms_pkg::EV_START, i2cms_pkg::EV_REP_START: begin
              res_o.tx_valid   = 1'b1;
              res_o.tx_data    = addr_byte_q;
              res_o.advance    = 1'b1;
              res_o.irq_enable = 1'b1;
            end
            i2cms_pkg::EV_SLAW_ACK, i2cms_pkg::EV_TX_ACK: begin
              if (remaining_q != 8'd0) begin
                // buffer byte is read out in the next cycle
                ram_re_o          = step_i;
                res_o.tx_valid    = 1'b1;
                res_o.tx_from_ram = 1'b1;
                ptr_d             = ptr_inc;
                remaining_d       = remaining_q - 8'd1;
                res_o.advance     = 1'b1;
                res_o.irq_enable  = 1'b1;
              end else begin
                active_d         = 1'b0;
                res_o.done       = 1'b1;
                res_o.done_count = total_q - remaining_q;
              end
            end
            i2cms_pkg::EV_SLAR_ACK: begin
              res_o.advance    = 1'b1;
              res_o.irq_enable = 1'b1;
              res_o.ack        = remaining_q > 8'd1;
            end
            i2cms_pkg::EV_RX_ACK: begin
              res_o.rx_valid   = 1'b1;
              res_o.rx_data    = rx_byte_i;
              remaining_d      = rem_dec;
              res_o.advance    = 1'b1;
              res_o.irq_enable = 1'b1;
              res_o.ack        = rem_dec > 8'd1;
            end
            i2cms_pkg::EV_RX_NACK: begin
              res_o.rx_valid   = 1'b1;
              res_o.rx_data    = rx_byte_i;
              remaining_d      = rem_dec;
              active_d         = 1'b0;
              res_o.done       = 1'b1;
              res_o.done_count = total_q - rem_dec;
            end
            i2cms_pkg::EV_ARB_LOST: begin
              res_o.advance    = 1'b1;
              res_o.start      = 1'b1;
              res_o.irq_enable = 1'b1;
            end
            default: begin
              active_d         = 1'b0;
              res_o.done       = 1'b1;
              res_o.error      = 1'b1;
              res_o.done_count = total_q - remaining_q;
            end
          endcase
        end
      end
      i2cms_pkg::CMD_STOP: begin
        active_d      = 1'b0;
        res_o.advance = 1'b1;
        res_o.stop    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      addr_byte_q <= 8'd0;
      total_q     <= 8'd0;
      remaining_q <= 8'd0;
      ptr_q       <= '0;
    end else if (step_i) begin
      active_q    <= active_d;
      addr_byte_q <= addr_byte_d;
      total_q     <= total_d;
      remaining_q <= remaining_d;
      ptr_q       <= ptr_d;
    end
  end

endmodule

[src/i2c_master_transfer_sequencer.sv]
// a result is registered and presented in the cycle after its input transaction is accepted
// throughput: one transaction per cycle unless the output stalls; the output register accepts a new result
// in the cycle its current one is taken, and the write buffer is read in the same cycle
// reset: transfer state, pointer and output valid clear asynchronously;
// the write buffer is not cleared and holds unknown bytes until loaded
module i2c_master_transfer_sequencer #(
  parameter int TX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] slave_addr_i,
  input  logic [7:0] xfer_len_i,
  input  logic [3:0] bus_event_i,
  input  logic [7:0] rx_byte_i,
  input  logic [3:0] wr_index_i,
  input  logic [7:0] wr_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ctl_advance_o,
  output logic       ctl_start_o,
  output logic       ctl_stop_o,
  output logic       ctl_ack_o,
  output logic       ctl_irq_enable_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_data_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_data_o,
  output logic       done_res_o,
  output logic       error_o,
  output logic [7:0] done_count_o
);

  localparam int AW = $clog2(TX_DEPTH);

  logic               step;
  i2cms_pkg::result_t res;
  i2cms_pkg::result_t res_q;
  logic               out_valid_q;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  i2cms_ctrl #(
    .TxDepth(TX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (cmd_i),
    .slave_addr_i(slave_addr_i),
    .xfer_len_i  (xfer_len_i),
    .bus_event_i (bus_event_i),
    .rx_byte_i   (rx_byte_i),
    .wr_index_i  (wr_index_i),
    .wr_byte_i   (wr_byte_i),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  // read data holds until the next accepted read, so a stalled result keeps its byte
  i2cms_ram #(
    .Width(8),
    .Depth(TX_DEPTH)
  ) u_tx_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ctl_advance_o    = res_q.advance;
  assign ctl_start_o      = res_q.start;
  assign ctl_stop_o       = res_q.stop;
  assign ctl_ack_o        = res_q.ack;
  assign ctl_irq_enable_o = res_q.irq_enable;
  assign tx_valid_o       = res_q.tx_valid;
  assign tx_data_o        = res_q.tx_from_ram ? ram_rdata : res_q.tx_data;
  assign rx_valid_o       = res_q.rx_valid;
  assign rx_data_o        = res_q.rx_data;
  assign done_res_o       = res_q.done;
  assign error_o          = res_q.error;
  assign done_count_o     = res_q.done_count;

endmodule

[src/i2cms_checker.sv]
module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       ctl_advance_o,
  input logic       ctl_start_o,
  input logic       ctl_stop_o,
  input logic       ctl_irq_enable_o,
  input logic       tx_valid_o,
  input logic       rx_valid_o,
  input logic       done_res_o,
  input logic [7:0] done_count_o
);

  // a finished transfer never lets the engine keep going
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !ctl_advance_o && !ctl_irq_enable_o)
    else $error("done result with advance or irq enable");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> done_count_o == 8'd0)
    else $error("count shown without done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tx_valid_o || ctl_stop_o) |-> !rx_valid_o && !done_res_o)
    else $error("transmit or stop mixed with receive or done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctl_stop_o |-> !ctl_start_o && !ctl_irq_enable_o && ctl_advance_o)
    else $error("bad stop control word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .ctl_advance_o   (ctl_advance_o),
  .ctl_start_o     (ctl_start_o),
  .ctl_stop_o      (ctl_stop_o),
  .ctl_irq_enable_o(ctl_irq_enable_o),
  .tx_valid_o      (tx_valid_o),
  .rx_valid_o      (rx_valid_o),
  .done_res_o      (done_res_o),
  .done_count_o    (done_count_o)
);

[verif/i2c_master_transfer_sequencer_tb.sv]
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_tb;

  localparam int TX_DEPTH = 16;
  localparam int TOTAL_ITEMS = 1100;
  localparam int QUIET_TAIL = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [3:0] EV_OTHER_LO = 4'd8;
  localparam logic [3:0] EV_OTHER_HI = 4'd15;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] addr;
    logic [7:0] len;
    logic [3:0] ev;
    logic [7:0] rx;
    logic [3:0] widx;
    logic [7:0] wbyte;
  } xfer_item_t;

  typedef struct packed {
    logic       advance;
    logic       start;
    logic       stop;
    logic       ack;
    logic       irq_enable;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done;
    logic       err;
    logic [7:0] done_count;
  } ctl_word_t;

  class transfer_tracker;
    bit         active;
    bit         read_mode;
    logic [7:0] addr_byte;
    logic [7:0] total_len;
    logic [7:0] remaining;
    logic [3:0] tx_ptr;
    logic [7:0] tx_buf [TX_DEPTH];
    bit         loaded [TX_DEPTH];
    ctl_word_t  pending_words [$];
    int         errors;

    function new();
      active = 1'b0;
      read_mode = 1'b0;
      addr_byte = '0;
      total_len = '0;
      remaining = '0;
      tx_ptr = '0;
      errors = 0;
      for (int i = 0; i < TX_DEPTH; i++) begin
        tx_buf[i] = '0;
        loaded[i] = 1'b0;
      end
    endfunction

    function void close_transfer(inout ctl_word_t w, input bit failed);
      active = 1'b0;
      w.advance = 1'b0;
      w.irq_enable = 1'b0;
      w.done = 1'b1;
      w.err = failed;
      w.done_count = total_len - remaining;
    endfunction

    function void note_transaction(xfer_item_t it);
      ctl_word_t w;
      w = '0;
      case (it.cmd)
        i2cms_pkg::CMD_START_WR, i2cms_pkg::CMD_START_RD: begin
          if (active) begin
            w.err = 1'b1;
          end else begin
            read_mode = it.cmd[0];
            addr_byte = {it.addr[7:1], it.cmd[0]};
            total_len = (it.cmd == i2cms_pkg::CMD_START_WR && it.len > 8'(TX_DEPTH)) ?
                        8'(TX_DEPTH) : it.len;
            remaining = total_len;
            tx_ptr = '0;
            active = 1'b1;
            w.advance = 1'b1;
            w.start = 1'b1;
            w.irq_enable = 1'b1;
          end
        end
        i2cms_pkg::CMD_LOAD_WR: begin
          tx_buf[it.widx] = it.wbyte;
          loaded[it.widx] = 1'b1;
        end
        i2cms_pkg::CMD_EVENT: begin
          if (active) begin
            case (it.ev)
              i2cms_pkg::EV_START, i2cms_pkg::EV_REP_START: begin
                w.tx_valid = 1'b1;
                w.tx_data = addr_byte;
                w.advance = 1'b1;
                w.irq_enable = 1'b1;
              end
              i2cms_pkg::EV_SLAW_ACK, i2cms_pkg::EV_TX_ACK: begin
                if (remaining != 8'd0) begin
                  w.tx_valid = 1'b1;
                  w.tx_data = tx_buf[tx_ptr];
                  tx_ptr = tx_ptr + 4'd1;
                  remaining = remaining - 8'd1;
                  w.advance = 1'b1;
                  w.irq_enable = 1'b1;
                end else begin
                  close_transfer(w, 1'b0);
                end
              end
              i2cms_pkg::EV_SLAR_ACK, i2cms_pkg::EV_RX_ACK: begin
                if (it.ev == i2cms_pkg::EV_RX_ACK) begin
                  w.rx_valid = 1'b1;
                  w.rx_data = it.rx;
                  if (remaining != 8'd0) remaining = remaining - 8'd1;
                end
                w.advance = 1'b1;
                w.irq_enable = 1'b1;
                w.ack = (remaining > 8'd1);
              end
              i2cms_pkg::EV_RX_NACK: begin
                w.rx_valid = 1'b1;
                w.rx_data = it.rx;
                if (remaining != 8'd0) remaining = remaining - 8'd1;
                close_transfer(w, 1'b0);
              end
              i2cms_pkg::EV_ARB_LOST: begin
                w.advance = 1'b1;
                w.start = 1'b1;
                w.irq_enable = 1'b1;
              end
              default: close_transfer(w, 1'b1);
            endcase
          end
        end
        i2cms_pkg::CMD_STOP: begin
          active = 1'b0;
          w.advance = 1'b1;
          w.stop = 1'b1;
        end
        default: ;
      endcase
      pending_words.push_back(w);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_word(ctl_word_t got);
      ctl_word_t want;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction outstanding: expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_words.pop_front();
      field_check("ctl_advance", 8'(want.advance), 8'(got.advance));
      field_check("ctl_start", 8'(want.start), 8'(got.start));
      field_check("ctl_stop", 8'(want.stop), 8'(got.stop));
      field_check("ctl_ack", 8'(want.ack), 8'(got.ack));
      field_check("ctl_irq_enable", 8'(want.irq_enable), 8'(got.irq_enable));
      field_check("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      field_check("tx_data", want.tx_data, got.tx_data);
      field_check("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      field_check("rx_data", want.rx_data, got.rx_data);
      field_check("done_res", 8'(want.done), 8'(got.done));
      field_check("error", 8'(want.err), 8'(got.err));
      field_check("done_count", want.done_count, got.done_count);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       out_ready_i = 1'b0;
  xfer_item_t drv_item = '0;

  logic       in_ready_o;
  logic [2:0] cmd_i;
  logic [7:0] slave_addr_i;
  logic [7:0] xfer_len_i;
  logic [3:0] bus_event_i;
  logic [7:0] rx_byte_i;
  logic [3:0] wr_index_i;
  logic [7:0] wr_byte_i;
  logic       out_valid_o;
  logic       ctl_advance_o;
  logic       ctl_start_o;
  logic       ctl_stop_o;
  logic       ctl_ack_o;
  logic       ctl_irq_enable_o;
  logic       tx_valid_o;
  logic [7:0] tx_data_o;
  logic       rx_valid_o;
  logic [7:0] rx_data_o;
  logic       done_res_o;
  logic       error_o;
  logic [7:0] done_count_o;
  ctl_word_t  seen_word;

  transfer_tracker tracker;
  bit idle_on = 1'b1;
  int items_done = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  assign cmd_i = drv_item.cmd;
  assign slave_addr_i = drv_item.addr;
  assign xfer_len_i = drv_item.len;
  assign bus_event_i = drv_item.ev;
  assign rx_byte_i = drv_item.rx;
  assign wr_index_i = drv_item.widx;
  assign wr_byte_i = drv_item.wbyte;

  assign seen_word = {ctl_advance_o, ctl_start_o, ctl_stop_o, ctl_ack_o, ctl_irq_enable_o,
                      tx_valid_o, tx_data_o, rx_valid_o, rx_data_o, done_res_o, error_o,
                      done_count_o};

  i2c_master_transfer_sequencer #(
    .TX_DEPTH(TX_DEPTH)
  ) DUT (
    .*
  );

  always #5 clk_i = ~clk_i;

  // result is checked before the same edge's transaction is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tracker.check_word(seen_word);
      if (in_valid_i && in_ready_o) tracker.note_transaction(drv_item);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready_i = 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[i2c_master_transfer_sequencer] ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  function automatic xfer_item_t make_item(logic [2:0] cmd, logic [3:0] ev);
    xfer_item_t it;
    it.cmd = cmd;
    it.addr = 8'($urandom);
    it.len = 8'($urandom);
    it.ev = ev;
    it.rx = 8'($urandom);
    it.widx = 4'($urandom);
    it.wbyte = 8'($urandom);
    return it;
  endfunction

  task automatic send(input xfer_item_t it);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    // never put a slot on the bus that was not loaded since reset
    if (it.cmd == i2cms_pkg::CMD_EVENT &&
        (it.ev == i2cms_pkg::EV_SLAW_ACK || it.ev == i2cms_pkg::EV_TX_ACK) &&
        tracker.active && tracker.remaining != 8'd0 && !tracker.loaded[tracker.tx_ptr]) begin
      it.cmd = i2cms_pkg::CMD_LOAD_WR;
      it.widx = tracker.tx_ptr;
    end
    items_done++;
    drv_item = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_event(input logic [3:0] ev);
    send(make_item(i2cms_pkg::CMD_EVENT, ev));
  endtask

  task automatic send_rx(input logic [3:0] ev, input logic [7:0] rxb);
    xfer_item_t it;
    it = make_item(i2cms_pkg::CMD_EVENT, ev);
    it.rx = rxb;
    send(it);
  endtask

  task automatic send_start(input logic [2:0] cmd, input logic [7:0] addr,
                            input logic [7:0] len);
    xfer_item_t it;
    it = make_item(cmd, 4'($urandom));
    it.addr = addr;
    it.len = len;
    send(it);
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [7:0] b);
    xfer_item_t it;
    it = make_item(i2cms_pkg::CMD_LOAD_WR, 4'($urandom));
    it.widx = idx;
    it.wbyte = b;
    send(it);
  endtask

  // occasional abort, busy start or stray load in the middle of a transfer
  task automatic maybe_disturb();
    int r;
    r = $urandom_range(0, 49);
    case (r)
      0: send_start($urandom_range(0, 1) ? i2cms_pkg::CMD_START_RD : i2cms_pkg::CMD_START_WR,
                    8'($urandom), 8'($urandom));
      1: send_event(4'($urandom_range(EV_OTHER_LO, EV_OTHER_HI)));
      2: send(make_item(i2cms_pkg::CMD_STOP, 4'($urandom)));
      3: send_load(4'($urandom), 8'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    bit rd;
    int n;
    int r;
    logic [7:0] len;
    tracker = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    send_event(i2cms_pkg::EV_START);
    send_load(4'd0, 8'hFF);
    send_load(4'd15, 8'h00);
    send_load(4'd1, 8'h5A);
    send_start(i2cms_pkg::CMD_START_WR, 8'hFF, 8'hFF);
    send_start(i2cms_pkg::CMD_START_RD, 8'h00, 8'h00);
    send_event(i2cms_pkg::EV_START);
    send_event(i2cms_pkg::EV_ARB_LOST);
    send_event(i2cms_pkg::EV_REP_START);
    send_event(i2cms_pkg::EV_SLAW_ACK);
    send_event(i2cms_pkg::EV_TX_ACK);
    send_event(EV_OTHER_HI);
    send_start(i2cms_pkg::CMD_START_WR, 8'h00, 8'h00);
    send_event(i2cms_pkg::EV_START);
    send_event(i2cms_pkg::EV_SLAW_ACK);
    send_start(i2cms_pkg::CMD_START_RD, 8'h81, 8'd2);
    send_event(i2cms_pkg::EV_SLAR_ACK);
    send_rx(i2cms_pkg::EV_RX_ACK, 8'hFF);
    send_rx(i2cms_pkg::EV_RX_ACK, 8'h00);
    send_rx(i2cms_pkg::EV_RX_ACK, 8'h3C);
    send_rx(i2cms_pkg::EV_RX_NACK, 8'hC3);
    send_start(i2cms_pkg::CMD_START_RD, 8'h7F, 8'hFF);
    send(make_item(i2cms_pkg::CMD_STOP, 4'($urandom)));
    send(make_item(CMD_UNUSED_HI, 4'($urandom)));
    send(make_item(CMD_UNUSED_LO, 4'($urandom)));
    send_event(EV_OTHER_LO);

    while (items_done < TOTAL_ITEMS) begin
      if (items_done > TOTAL_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      if ($urandom_range(0, 6) == 0) begin
        send(make_item(3'($urandom_range(0, CMD_UNUSED_HI)), 4'($urandom)));
      end else begin
        rd = 1'($urandom_range(0, 1));
        n = $urandom_range(0, 3);
        repeat (n) send_load(4'($urandom), 8'($urandom));
        r = $urandom_range(0, 39);
        if (r == 0) len = 8'hFF;
        else if (r < 4) len = 8'($urandom);
        else len = 8'($urandom_range(0, 12));
        send_start(rd ? i2cms_pkg::CMD_START_RD : i2cms_pkg::CMD_START_WR, 8'($urandom), len);
        if ($urandom_range(0, 7) == 0) send_event(i2cms_pkg::EV_ARB_LOST);
        send_event($urandom_range(0, 3) == 0 ? i2cms_pkg::EV_REP_START : i2cms_pkg::EV_START);
        if (rd) begin
          send_event(i2cms_pkg::EV_SLAR_ACK);
          for (int k = 1; k < int'(len); k++) begin
            maybe_disturb();
            send_event(i2cms_pkg::EV_RX_ACK);
          end
          // reading past the end drives the count to saturation
          if ($urandom_range(0, 9) == 0) send_event(i2cms_pkg::EV_RX_ACK);
          send_event(i2cms_pkg::EV_RX_NACK);
        end else begin
          send_event(i2cms_pkg::EV_SLAW_ACK);
          n = (len > 8'(TX_DEPTH)) ? TX_DEPTH : int'(len);
          repeat (n) begin
            maybe_disturb();
            send_event(i2cms_pkg::EV_TX_ACK);
          end
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("[i2c_master_transfer_sequencer] OK");
    end else begin
      $display("[i2c_master_transfer_sequencer] ERROR");
    end
    $finish;
  end

endmodule
